### rtl/alu8_pkg.sv
// ----------------------------------------------------------------------------
// alu8_pkg
// Shared types and constants of the eight-bit ALU with Z N H C flags.
// ----------------------------------------------------------------------------
package alu8_pkg;

  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,
    OP_ADC  = 5'd1,
    OP_SUB  = 5'd2,
    OP_SBC  = 5'd3,
    OP_AND  = 5'd4,
    OP_XOR  = 5'd5,
    OP_OR   = 5'd6,
    OP_CP   = 5'd7,
    OP_INC  = 5'd8,
    OP_DEC  = 5'd9,
    OP_RLCA = 5'd10,
    OP_RRCA = 5'd11,
    OP_RLA  = 5'd12,
    OP_RRA  = 5'd13,
    OP_DAA  = 5'd14,
    OP_CPL  = 5'd15,
    OP_SCF  = 5'd16,
    OP_CCF  = 5'd17,
    OP_RLC  = 5'd18,
    OP_RRC  = 5'd19,
    OP_RL   = 5'd20,
    OP_RR   = 5'd21,
    OP_SLA  = 5'd22,
    OP_SRA  = 5'd23,
    OP_SWAP = 5'd24,
    OP_SRL  = 5'd25,
    OP_BIT  = 5'd26,
    OP_RES  = 5'd27,
    OP_SET  = 5'd28
  } alu_op_t;

  localparam int FLAG_Z = 3;
  localparam int FLAG_N = 2;
  localparam int FLAG_H = 1;
  localparam int FLAG_C = 0;

  localparam logic [7:0] DAA_HIGH_ADJ = 8'h60;
  localparam logic [7:0] DAA_LOW_ADJ  = 8'h06;
  localparam logic [7:0] DAA_BCD_MAX  = 8'h99;
  localparam logic [3:0] DAA_DIGIT_MAX = 4'h9;

  typedef struct packed {
    logic [4:0] req_type;
    logic [7:0] acc;
    logic [7:0] operand;
    logic [2:0] bit_index;
    logic [3:0] flags_in;
  } req_t;

  typedef struct packed {
    logic [7:0] result;
    logic [3:0] flags_out;
    logic       writes_result;
  } rsp_t;

endpackage

### rtl/alu8_core.sv
// ----------------------------------------------------------------------------
// alu8_core
// Combinational datapath: computes the result byte, the new flags and the
// write-back mark for one operation.
// ----------------------------------------------------------------------------
module alu8_core (
  input  alu8_pkg::req_t req,
  output alu8_pkg::rsp_t rsp
);
  import alu8_pkg::*;

  logic [7:0] a;
  logic [7:0] b;
  logic       cin;
  logic       hin;
  logic       nin;
  logic       zin;
  logic       t;
  logic [8:0] sum9;
  logic [4:0] sum5;
  logic [8:0] dif9;
  logic [4:0] dif5;
  logic [7:0] inc8;
  logic [7:0] dec8;
  logic [7:0] daa_adj;
  logic       daa_c;
  logic [7:0] daa_res;
  logic [7:0] bit_mask;
  logic [7:0] r;
  logic       z;
  logic       n;
  logic       h;
  logic       c;
  logic       wr;

  always_comb begin
    a        = req.acc;
    b        = req.operand;
    cin      = req.flags_in[FLAG_C];
    hin      = req.flags_in[FLAG_H];
    nin      = req.flags_in[FLAG_N];
    zin      = req.flags_in[FLAG_Z];
    t        = ((req.req_type == OP_ADC) || (req.req_type == OP_SBC)) ? cin : 1'b0;
    sum9     = {1'b0, a} + {1'b0, b} + {8'd0, t};
    sum5     = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, t};
    dif9     = {1'b0, a} - {1'b0, b} - {8'd0, t};
    dif5     = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, t};
    inc8     = b + 8'd1;
    dec8     = b - 8'd1;
    bit_mask = 8'd1 << req.bit_index;

    daa_adj = 8'd0;
    daa_c   = cin;
    if (!nin) begin
      if (cin || (a > DAA_BCD_MAX)) begin
        daa_adj = daa_adj | DAA_HIGH_ADJ;
        daa_c   = 1'b1;
      end
      if (hin || (a[3:0] > DAA_DIGIT_MAX)) begin
        daa_adj = daa_adj | DAA_LOW_ADJ;
      end
      daa_res = a + daa_adj;
    end else begin
      if (cin) begin
        daa_adj = daa_adj | DAA_HIGH_ADJ;
      end
      if (hin) begin
        daa_adj = daa_adj | DAA_LOW_ADJ;
      end
      daa_res = a - daa_adj;
    end

    r  = a;
    z  = zin;
    n  = nin;
    h  = hin;
    c  = cin;
    wr = 1'b1;

    case (req.req_type)
      OP_ADD, OP_ADC: begin
        r = sum9[7:0];
        z = (r == 8'd0);
        n = 1'b0;
        h = sum5[4];
        c = sum9[8];
      end
      OP_SUB, OP_SBC, OP_CP: begin
        r = dif9[7:0];
        z = (r == 8'd0);
        n = 1'b1;
        h = dif5[4];
        c = dif9[8];
        if (req.req_type == OP_CP) begin
          r  = a;
          wr = 1'b0;
        end
      end
      OP_AND: begin
        r = a & b;
        z = (r == 8'd0);
        n = 1'b0;
        h = 1'b1;
        c = 1'b0;
      end
      OP_XOR, OP_OR: begin
        r = (req.req_type == OP_XOR) ? (a ^ b) : (a | b);
        z = (r == 8'd0);
        n = 1'b0;
        h = 1'b0;
        c = 1'b0;
      end
      OP_INC: begin
        r = inc8;
        z = (r == 8'd0);
        n = 1'b0;
        h = (b[3:0] == 4'hF);
      end
      OP_DEC: begin
        r = dec8;
        z = (r == 8'd0);
        n = 1'b1;
        h = (b[3:0] == 4'h0);
      end
      OP_RLCA, OP_RLA: begin
        r = {a[6:0], (req.req_type == OP_RLCA) ? a[7] : cin};
        z = 1'b0;
        n = 1'b0;
        h = 1'b0;
        c = a[7];
      end
      OP_RRCA, OP_RRA: begin
        r = {(req.req_type == OP_RRCA) ? a[0] : cin, a[7:1]};
        z = 1'b0;
        n = 1'b0;
        h = 1'b0;
        c = a[0];
      end
      OP_DAA: begin
        r = daa_res;
        z = (r == 8'd0);
        h = 1'b0;
        c = daa_c;
      end
      OP_CPL: begin
        r = ~a;
        n = 1'b1;
        h = 1'b1;
      end
      OP_SCF, OP_CCF: begin
        n  = 1'b0;
        h  = 1'b0;
        c  = (req.req_type == OP_SCF) ? 1'b1 : ~cin;
        wr = 1'b0;
      end
      OP_RLC, OP_RL, OP_SLA: begin
        case (req.req_type)
          OP_RLC:  r = {b[6:0], b[7]};
          OP_RL:   r = {b[6:0], cin};
          default: r = {b[6:0], 1'b0};
        endcase
        z = (r == 8'd0);
        n = 1'b0;
        h = 1'b0;
        c = b[7];
      end
      OP_RRC, OP_RR, OP_SRA, OP_SRL: begin
        case (req.req_type)
          OP_RRC:  r = {b[0], b[7:1]};
          OP_RR:   r = {cin, b[7:1]};
          OP_SRA:  r = {b[7], b[7:1]};
          default: r = {1'b0, b[7:1]};
        endcase
        z = (r == 8'd0);
        n = 1'b0;
        h = 1'b0;
        c = b[0];
      end
      OP_SWAP: begin
        r = {b[3:0], b[7:4]};
        z = (r == 8'd0);
        n = 1'b0;
        h = 1'b0;
        c = 1'b0;
      end
      OP_BIT: begin
        r  = b;
        z  = ~b[req.bit_index];
        n  = 1'b0;
        h  = 1'b1;
        wr = 1'b0;
      end
      OP_RES: begin
        r = b & ~bit_mask;
      end
      OP_SET: begin
        r = b | bit_mask;
      end
      default: begin
        r  = a;
        wr = 1'b0;
      end
    endcase

    rsp.result        = r;
    rsp.flags_out     = {z, n, h, c};
    rsp.writes_result = wr;
  end

endmodule

### rtl/cpu_alu_8bit_with_flags_top.sv
// ----------------------------------------------------------------------------
// cpu_alu_8bit_with_flags_top
// Eight-bit ALU with Z N H C flags: input register, combinational datapath,
// result register.
// ----------------------------------------------------------------------------
// Each transaction on the request channel carries an operation code, the
// accumulator, an operand, a bit index and the incoming flags; exactly one
// transaction appears on the response channel for it, having passed the input
// register and then the result register, and in request order.
// The block accepts one transaction every cycle when neither channel stalls:
// the input register and the result register form a two-stage pipeline
// around a single combinational pass; throughput is one operation per clock.
module cpu_alu_8bit_with_flags_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  alu8_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output alu8_pkg::rsp_t rsp
);
  import alu8_pkg::*;

  req_t req_q;
  logic req_q_valid;
  rsp_t rsp_next;
  logic advance;

  assign advance   = !rsp_valid || !rsp_stall;
  assign req_stall = req_q_valid && !advance;

  alu8_core u_core (
    .req (req_q),
    .rsp (rsp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_q_valid <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      if (!req_stall) begin
        req_q_valid <= req_valid;
      end
      if (advance) begin
        rsp_valid <= req_q_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      req_q <= req;
    end
    if (advance && req_q_valid) begin
      rsp <= rsp_next;
    end
  end

endmodule

### tb/alu8_ledger_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// alu8_ledger_pkg
// Predicts the outcome of each ALU request and keeps the expected responses
// in request order, checking every response against the oldest one waiting.
// ----------------------------------------------------------------------------
package alu8_ledger_pkg;

  import alu8_pkg::*;

  function automatic rsp_t alu_outcome(req_t q);
    rsp_t       o;
    logic [7:0] a, b, r, adj;
    logic [8:0] wide;
    logic [4:0] nib;
    logic [3:0] fin, f;
    logic       c, carry_in, cy, wr;
    a   = q.acc;
    b   = q.operand;
    fin = q.flags_in;
    c   = fin[FLAG_C];
    r   = a;
    f   = fin;
    wr  = 1'b1;
    case (q.req_type)
      OP_ADD, OP_ADC: begin
        carry_in = (q.req_type == OP_ADC) & c;
        wide = {1'b0, a} + {1'b0, b} + {8'd0, carry_in};
        nib  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, carry_in};
        r    = wide[7:0];
        f    = {r == 8'h00, 1'b0, nib[4], wide[8]};
      end
      OP_SUB, OP_SBC, OP_CP: begin
        carry_in = (q.req_type == OP_SBC) & c;
        wide = {1'b0, a} - {1'b0, b} - {8'd0, carry_in};
        nib  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, carry_in};
        r    = wide[7:0];
        f    = {r == 8'h00, 1'b1, nib[4], wide[8]};
        if (q.req_type == OP_CP) begin
          r  = a;
          wr = 1'b0;
        end
      end
      OP_AND: begin
        r = a & b;
        f = {r == 8'h00, 1'b0, 1'b1, 1'b0};
      end
      OP_XOR: begin
        r = a ^ b;
        f = {r == 8'h00, 3'b000};
      end
      OP_OR: begin
        r = a | b;
        f = {r == 8'h00, 3'b000};
      end
      OP_INC: begin
        r = b + 8'd1;
        f = {r == 8'h00, 1'b0, b[3:0] == 4'hF, c};
      end
      OP_DEC: begin
        r = b - 8'd1;
        f = {r == 8'h00, 1'b1, b[3:0] == 4'h0, c};
      end
      OP_RLCA: begin
        r = {a[6:0], a[7]};
        f = {3'b000, a[7]};
      end
      OP_RRCA: begin
        r = {a[0], a[7:1]};
        f = {3'b000, a[0]};
      end
      OP_RLA: begin
        r = {a[6:0], c};
        f = {3'b000, a[7]};
      end
      OP_RRA: begin
        r = {c, a[7:1]};
        f = {3'b000, a[0]};
      end
      OP_DAA: begin
        adj = 8'h00;
        cy  = c;
        if (!fin[FLAG_N]) begin
          if (c || a > DAA_BCD_MAX) begin
            adj = adj | DAA_HIGH_ADJ;
            cy  = 1'b1;
          end
          if (fin[FLAG_H] || a[3:0] > DAA_DIGIT_MAX) adj = adj | DAA_LOW_ADJ;
          r = a + adj;
        end else begin
          if (c) adj = adj | DAA_HIGH_ADJ;
          if (fin[FLAG_H]) adj = adj | DAA_LOW_ADJ;
          r = a - adj;
        end
        f = {r == 8'h00, fin[FLAG_N], 1'b0, cy};
      end
      OP_CPL: begin
        r = ~a;
        f = {fin[FLAG_Z], 1'b1, 1'b1, c};
      end
      OP_SCF: begin
        f  = {fin[FLAG_Z], 3'b001};
        wr = 1'b0;
      end
      OP_CCF: begin
        f  = {fin[FLAG_Z], 2'b00, ~c};
        wr = 1'b0;
      end
      OP_RLC: begin
        r = {b[6:0], b[7]};
        f = {r == 8'h00, 2'b00, b[7]};
      end
      OP_RRC: begin
        r = {b[0], b[7:1]};
        f = {r == 8'h00, 2'b00, b[0]};
      end
      OP_RL: begin
        r = {b[6:0], c};
        f = {r == 8'h00, 2'b00, b[7]};
      end
      OP_RR: begin
        r = {c, b[7:1]};
        f = {r == 8'h00, 2'b00, b[0]};
      end
      OP_SLA: begin
        r = {b[6:0], 1'b0};
        f = {r == 8'h00, 2'b00, b[7]};
      end
      OP_SRA: begin
        r = {b[7], b[7:1]};
        f = {r == 8'h00, 2'b00, b[0]};
      end
      OP_SWAP: begin
        r = {b[3:0], b[7:4]};
        f = {r == 8'h00, 3'b000};
      end
      OP_SRL: begin
        r = {1'b0, b[7:1]};
        f = {r == 8'h00, 2'b00, b[0]};
      end
      OP_BIT: begin
        r  = b;
        f  = {~b[q.bit_index], 1'b0, 1'b1, c};
        wr = 1'b0;
      end
      OP_RES: r = b & ~(8'd1 << q.bit_index);
      OP_SET: r = b | (8'd1 << q.bit_index);
      default: begin
        r  = a;
        f  = fin;
        wr = 1'b0;
      end
    endcase
    o.result        = r;
    o.flags_out     = f;
    o.writes_result = wr;
    return o;
  endfunction

  class alu_result_ledger;
    rsp_t        pending[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    function void note_request(req_t q);
      pending.push_back(alu_outcome(q));
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected response, result %h flags %h write %b",
                 $time, got.result, got.flags_out, got.writes_result);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.result !== want.result) begin
        $display("%0t: result expected %h got %h", $time, want.result, got.result);
        errors++;
      end
      if (got.flags_out !== want.flags_out) begin
        $display("%0t: flags_out expected %h got %h", $time, want.flags_out,
                 got.flags_out);
        errors++;
      end
      if (got.writes_result !== want.writes_result) begin
        $display("%0t: writes_result expected %b got %b", $time, want.writes_result,
                 got.writes_result);
        errors++;
      end
    endfunction
  endclass

endpackage

### tb/tb_cpu_alu_8bit_with_flags_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cpu_alu_8bit_with_flags_top
// Drives directed corner cases and random ALU requests, including add or
// subtract followed by decimal adjust, with random idling and stalls on both
// channels, and checks every response against the predicted outcome.
// ----------------------------------------------------------------------------
module tb_cpu_alu_8bit_with_flags_top;

  import alu8_pkg::*;
  import alu8_ledger_pkg::*;

  localparam logic [4:0]  OP_UNUSED_HI = 5'd31;
  localparam int unsigned RANDOM_ITEMS = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 500000;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic rsp_stall = 1'b0;
  req_t req       = '0;
  logic req_stall;
  logic rsp_valid;
  rsp_t rsp;

  logic             calm   = 1'b0;
  int unsigned      cycles = 0;
  alu_result_ledger ledger = new();

  cpu_alu_8bit_with_flags_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("cpu_alu_8bit_with_flags_top verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) ledger.note_request(req);
      if (rsp_valid && !rsp_stall) ledger.check_response(rsp);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (calm || roll < 55) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(24, 6);
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(15))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      4: return 8'h0F;
      5: return 8'hF0;
      6: return 8'h99;
      default: return 8'($urandom());
    endcase
  endfunction

  function automatic logic [7:0] bcd_byte();
    return {4'($urandom_range(9)), 4'($urandom_range(9))};
  endfunction

  function automatic req_t alu_req(logic [4:0] op, logic [7:0] a, logic [7:0] b,
                                   logic [2:0] idx, logic [3:0] f);
    req_t q;
    q.req_type  = op;
    q.acc       = a;
    q.operand   = b;
    q.bit_index = idx;
    q.flags_in  = f;
    return q;
  endfunction

  task automatic send_req(req_t q);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= q;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  initial begin
    int unsigned hold;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      hold = pick_gap();
      if (hold != 0) begin
        rsp_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  end

  initial begin
    int unsigned n;
    req_t        q;
    rsp_t        guess;
    logic [4:0]  op;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_req(alu_req(OP_ADD,  8'hFF, 8'h01, 3'd0, 4'h0));
    send_req(alu_req(OP_ADC,  8'h0F, 8'h00, 3'd0, 4'h1));
    send_req(alu_req(OP_SUB,  8'h3C, 8'h3C, 3'd0, 4'h0));
    send_req(alu_req(OP_SBC,  8'h00, 8'h00, 3'd0, 4'h1));
    send_req(alu_req(OP_AND,  8'h00, 8'hFF, 3'd0, 4'hF));
    send_req(alu_req(OP_XOR,  8'hFF, 8'hFF, 3'd0, 4'h0));
    send_req(alu_req(OP_OR,   8'h00, 8'h00, 3'd0, 4'h0));
    send_req(alu_req(OP_CP,   8'h10, 8'h20, 3'd0, 4'h0));
    send_req(alu_req(OP_INC,  8'h00, 8'hFF, 3'd0, 4'h1));
    send_req(alu_req(OP_DEC,  8'h00, 8'h10, 3'd0, 4'h8));
    send_req(alu_req(OP_RLCA, 8'h80, 8'h00, 3'd0, 4'hF));
    send_req(alu_req(OP_RRCA, 8'h01, 8'h00, 3'd0, 4'h8));
    send_req(alu_req(OP_RLA,  8'h80, 8'h00, 3'd0, 4'h0));
    send_req(alu_req(OP_RRA,  8'h01, 8'h00, 3'd0, 4'h0));
    send_req(alu_req(OP_DAA,  8'h9A, 8'h00, 3'd0, 4'h0));
    send_req(alu_req(OP_DAA,  8'h00, 8'h00, 3'd0, 4'h6));
    send_req(alu_req(OP_DAA,  8'h00, 8'h00, 3'd0, 4'h5));
    send_req(alu_req(OP_CPL,  8'h5A, 8'h00, 3'd0, 4'h9));
    send_req(alu_req(OP_SCF,  8'hFF, 8'h00, 3'd0, 4'hE));
    send_req(alu_req(OP_CCF,  8'h00, 8'h00, 3'd0, 4'h9));
    send_req(alu_req(OP_RLC,  8'h00, 8'h80, 3'd0, 4'h0));
    send_req(alu_req(OP_RRC,  8'h00, 8'h01, 3'd0, 4'h0));
    send_req(alu_req(OP_RL,   8'h00, 8'h80, 3'd0, 4'h0));
    send_req(alu_req(OP_RR,   8'h00, 8'h01, 3'd0, 4'h1));
    send_req(alu_req(OP_SLA,  8'h00, 8'h80, 3'd0, 4'h0));
    send_req(alu_req(OP_SRA,  8'h00, 8'h81, 3'd0, 4'h0));
    send_req(alu_req(OP_SWAP, 8'h00, 8'hF0, 3'd0, 4'hF));
    send_req(alu_req(OP_SRL,  8'h00, 8'h01, 3'd0, 4'h0));
    send_req(alu_req(OP_BIT,  8'h00, 8'h7F, 3'd7, 4'h0));
    send_req(alu_req(OP_RES,  8'h00, 8'hFF, 3'd7, 4'hA));
    send_req(alu_req(OP_SET,  8'h00, 8'h00, 3'd0, 4'h5));
    send_req(alu_req(OP_UNUSED_HI, 8'hA5, 8'h5A, 3'd3, 4'hF));

    n = 0;
    while (n < RANDOM_ITEMS) begin
      if (n % 200 == 0) calm = ($urandom_range(3) == 0);
      if ($urandom_range(99) < 15) begin
        op = 5'($urandom_range(OP_SBC, OP_ADD));
        q  = alu_req(op, bcd_byte(), bcd_byte(), 3'($urandom()), 4'($urandom()));
        send_req(q);
        guess = alu_outcome(q);
        send_req(alu_req(OP_DAA, guess.result, 8'($urandom()), 3'($urandom()),
                         guess.flags_out));
        n += 2;
      end else begin
        send_req(alu_req(5'($urandom_range(OP_UNUSED_HI, 0)), pick_byte(), pick_byte(),
                         3'($urandom()), 4'($urandom())));
        n++;
      end
    end
    req_valid <= 1'b0;

    while (ledger.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (ledger.errors == 0) begin
      $display("cpu_alu_8bit_with_flags_top verification clean");
    end else begin
      $display("cpu_alu_8bit_with_flags_top verification failed");
    end
    $finish;
  end

endmodule

### cpu_alu_8bit_with_flags_top.f
rtl/alu8_pkg.sv
rtl/alu8_core.sv
rtl/cpu_alu_8bit_with_flags_top.sv
tb/alu8_ledger_pkg.sv
tb/tb_cpu_alu_8bit_with_flags_top.sv
